### design/lbpm_pkg.sv
// Shared constants and types of the light bar pair matcher.
package lbpm_pkg;

  localparam int MAX_BARS   = 8;
  localparam int IDX_W      = $clog2(MAX_BARS);
  localparam int CNT_W      = $clog2(MAX_BARS + 1);
  localparam int RESULT_CAP = 28;
  localparam int RES_W      = $clog2(RESULT_CAP + 1);
  localparam int COORD_W    = 15;
  localparam int CFG_W      = 16;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_WANTED_COLOR  = 3'd0,
    CFG_MIN_RATIO     = 3'd1,
    CFG_MIN_SMALL     = 3'd2,
    CFG_MAX_SMALL     = 3'd3,
    CFG_MIN_LARGE     = 3'd4,
    CFG_MAX_LARGE     = 3'd5,
    CFG_MAX_TANGENT   = 3'd6
  } cfg_idx_t;

  // one stored bar
  typedef struct packed {
    logic               color;
    logic [COORD_W-1:0] len;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] ty;
    logic [COORD_W-1:0] tx;
  } bar_t;

  // bar store write from the front end
  typedef struct packed {
    logic             we;
    logic             bank;
    logic [IDX_W-1:0] idx;
    bar_t             bar;
  } bar_wr_t;

  // one frame waiting for pair testing
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

endpackage

### design/lbpm_front.sv
// Front end: takes bar words, writes the bar store and queues finished frames.
module lbpm_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [111:0]           in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tlast,
  input  logic                   q_full,
  output logic                   q_push,
  output lbpm_pkg::job_t         q_job,
  output lbpm_pkg::bar_wr_t      bar_wr
);
  import lbpm_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             bank_r;
  logic             accept;
  logic             room;

  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign room      = count_r < CNT_W'(MAX_BARS);

  // store write
  always_comb begin
    bar_wr.we        = accept & room;
    bar_wr.bank      = bank_r;
    bar_wr.idx       = IDX_W'(count_r);
    bar_wr.bar.tx    = in_tdata[14:0];
    bar_wr.bar.ty    = in_tdata[29:15];
    bar_wr.bar.bx    = in_tdata[44:30];
    bar_wr.bar.by    = in_tdata[59:45];
    bar_wr.bar.cx    = in_tdata[74:60];
    bar_wr.bar.cy    = in_tdata[89:75];
    bar_wr.bar.len   = in_tdata[104:90];
    bar_wr.bar.color = in_tuser;
  end

  // frame hand-off
  assign q_push      = accept & in_tlast;
  assign q_job.bank  = bank_r;
  assign q_job.count = room ? count_r + CNT_W'(1) : count_r;
  assign q_job.ovf   = ovf_r | ~room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        bank_r  <= ~bank_r;
      end else if (room) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

endmodule

### design/lbpm_job_queue.sv
// Two-entry queue of finished frames between front and back end.
module lbpm_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lbpm_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output lbpm_pkg::job_t head
);
  import lbpm_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/lbpm_back.sv
// Back end: bar store, pair sequencer, shared multiplier and result register.
module lbpm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [lbpm_pkg::CFG_W-1:0] cfg_wdata,
  input  lbpm_pkg::bar_wr_t         bar_wr,
  input  logic                      job_valid,
  input  lbpm_pkg::job_t            job,
  output logic                      job_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,
  output logic [2:0]                out_tuser,
  output logic                      out_tlast
);
  import lbpm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RDI   = 10'b0000000010,
    S_RDJ   = 10'b0000000100,
    S_CAP   = 10'b0000001000,
    S_BOX   = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_ARITH = 10'b0001000000,
    S_PUSH  = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  // configuration
  logic        wanted_r;
  logic [8:0]  ratio_r;
  logic [11:0] min_small_r, max_small_r, min_large_r, max_large_r;
  logic [15:0] tangent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r    <= 1'b0;
      ratio_r     <= 9'd179;
      min_small_r <= 12'd205;
      max_small_r <= 12'd819;
      min_large_r <= 12'd819;
      max_large_r <= 12'd1280;
      tangent_r   <= 16'd149;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WANTED_COLOR: wanted_r    <= cfg_wdata[0];
        CFG_MIN_RATIO:    ratio_r     <= cfg_wdata[8:0];
        CFG_MIN_SMALL:    min_small_r <= cfg_wdata[11:0];
        CFG_MAX_SMALL:    max_small_r <= cfg_wdata[11:0];
        CFG_MIN_LARGE:    min_large_r <= cfg_wdata[11:0];
        CFG_MAX_LARGE:    max_large_r <= cfg_wdata[11:0];
        CFG_MAX_TANGENT:  tangent_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // bar store, two banks, one read port
  bar_t             mem [2**(IDX_W+1)];
  bar_t             rd_r;
  logic [IDX_W-1:0] addr_c;

  always_ff @(posedge clk) begin
    if (bar_wr.we) mem[{bar_wr.bank, bar_wr.idx}] <= bar_wr.bar;
    rd_r <= mem[{job.bank, addr_c}];
  end

  function automatic logic [COORD_W-1:0] min4(input logic [COORD_W-1:0] a, b, c, d);
    logic [COORD_W-1:0] p, q;
    p = (a < b) ? a : b;
    q = (c < d) ? c : d;
    return (p < q) ? p : q;
  endfunction

  function automatic logic [COORD_W-1:0] max4(input logic [COORD_W-1:0] a, b, c, d);
    logic [COORD_W-1:0] p, q;
    p = (a > b) ? a : b;
    q = (c > d) ? c : d;
    return (p > q) ? p : q;
  endfunction

  function automatic logic in_box(input logic [COORD_W-1:0] x, y,
                                  input logic [COORD_W:0] xl, xh, yl, yh);
    return ({1'b0, x} >= xl) && ({1'b0, x} < xh) && ({1'b0, y} >= yl) && ({1'b0, y} < yh);
  endfunction

  state_t             state_r;
  logic [IDX_W-1:0]   i_r, j_r, k_r;
  bar_t               bi_r, bj_r;
  logic [COORD_W:0]   xl_r, xh_r, yl_r, yh_r;
  logic [COORD_W-1:0] dx_r, dy_r, sh_r, lo_r;
  logic [COORD_W:0]   s_r;
  logic [3:0]         step_r;
  logic [27:0]        mul_a, mul_b;
  logic [55:0]        prod_r;
  logic [29:0]        dxx_r;
  logic [48:0]        d2_r;
  logic               ratio_ok_r, angle_ok_r, a_ok_r, b_ok_r, c_le_r, c_gt_r;
  logic               pend_v_r, pend_large_r, new_large_r;
  logic [IDX_W-1:0]   pend_i_r, pend_j_r;
  logic [RES_W-1:0]   nres_r;
  logic               can_push;
  logic               load_out_c;
  logic               skip_c, hit_c, qual_c;
  logic [COORD_W-1:0] xmin_c, xmax_c, ymin_c, ymax_c;

  assign can_push   = ~out_tvalid | out_tready;
  // a new result word enters the output register this cycle
  assign load_out_c = ((state_r == S_PUSH) || (state_r == S_FIN)) && can_push;

  // read address by phase
  always_comb begin
    unique case (state_r)
      S_RDI:   addr_c = i_r;
      S_RDJ:   addr_c = j_r;
      S_SCAN:  addr_c = k_r + IDX_W'(1);
      default: addr_c = '0;
    endcase
  end

  // containment of the bar now on the read port
  assign skip_c = ({rd_r.cy, rd_r.cx} == {bi_r.cy, bi_r.cx}) ||
                  ({rd_r.cy, rd_r.cx} == {bj_r.cy, bj_r.cx});
  assign hit_c  = ~skip_c &&
                  (in_box(rd_r.tx, rd_r.ty, xl_r, xh_r, yl_r, yh_r) ||
                   in_box(rd_r.bx, rd_r.by, xl_r, xh_r, yl_r, yh_r) ||
                   in_box(rd_r.cx, rd_r.cy, xl_r, xh_r, yl_r, yh_r));

  assign xmin_c = min4(bi_r.tx, bi_r.bx, bj_r.tx, bj_r.bx);
  assign xmax_c = max4(bi_r.tx, bi_r.bx, bj_r.tx, bj_r.bx);
  assign ymin_c = min4(bi_r.ty, bi_r.by, bj_r.ty, bj_r.by);
  assign ymax_c = max4(bi_r.ty, bi_r.by, bj_r.ty, bj_r.by);

  // shared multiplier operands, one product per step
  always_comb begin
    case (step_r)
      4'd0:    begin mul_a = 28'(dx_r);        mul_b = 28'(dx_r); end
      4'd1:    begin mul_a = 28'(dy_r);        mul_b = 28'(dy_r); end
      4'd2:    begin mul_a = 28'(ratio_r);     mul_b = 28'(lo_r); end
      4'd3:    begin mul_a = 28'(tangent_r);   mul_b = 28'(dx_r); end
      4'd4:    begin mul_a = 28'(min_small_r); mul_b = 28'(s_r);  end
      4'd6:    begin mul_a = 28'(max_small_r); mul_b = 28'(s_r);  end
      4'd8:    begin mul_a = 28'(min_large_r); mul_b = 28'(s_r);  end
      4'd10:   begin mul_a = 28'(max_large_r); mul_b = 28'(s_r);  end
      4'd5, 4'd7, 4'd9, 4'd11:
               begin mul_a = prod_r[27:0];     mul_b = prod_r[27:0]; end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign qual_c = ratio_ok_r & angle_ok_r &
                  ((a_ok_r & b_ok_r) | (c_le_r & (56'(d2_r) < prod_r)));

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // consume the previous step's product
  always_ff @(posedge clk) begin
    if (state_r == S_ARITH) begin
      case (step_r)
        4'd1:  dxx_r      <= prod_r[29:0];
        4'd2:  d2_r       <= {31'(dxx_r) + 31'(prod_r[29:0]), 18'b0};
        4'd3:  ratio_ok_r <= 56'({sh_r, 8'b0}) > prod_r;
        4'd4:  angle_ok_r <= 56'({dy_r, 8'b0}) < prod_r;
        4'd6:  a_ok_r     <= prod_r <= 56'(d2_r);
        4'd8:  b_ok_r     <= 56'(d2_r) < prod_r;
        4'd10: begin
          c_le_r <= prod_r <= 56'(d2_r);
          c_gt_r <= 56'(d2_r) > prod_r;
        end
        default: ;
      endcase
    end
  end

  // pair data and box
  always_ff @(posedge clk) begin
    if (state_r == S_RDJ) bi_r <= rd_r;
    if (state_r == S_CAP) bj_r <= rd_r;
    if (state_r == S_BOX) begin
      xl_r <= {1'b0, xmin_c & 15'h7FF0};
      xh_r <= {1'b0, xmax_c & 15'h7FF0} + 16'd16;
      yl_r <= {1'b0, ymin_c & 15'h7FF0};
      yh_r <= {1'b0, ymax_c & 15'h7FF0} + 16'd16;
      dx_r <= (bi_r.cx > bj_r.cx) ? bi_r.cx - bj_r.cx : bj_r.cx - bi_r.cx;
      dy_r <= (bi_r.cy > bj_r.cy) ? bi_r.cy - bj_r.cy : bj_r.cy - bi_r.cy;
      sh_r <= (bi_r.len < bj_r.len) ? bi_r.len : bj_r.len;
      lo_r <= (bi_r.len < bj_r.len) ? bj_r.len : bi_r.len;
      s_r  <= 16'(bi_r.len) + 16'(bj_r.len);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      step_r     <= '0;
      pend_v_r   <= 1'b0;
      nres_r     <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && !load_out_c) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            i_r     <= '0;
            j_r     <= IDX_W'(1);
            state_r <= (job.count < CNT_W'(2)) ? S_FIN : S_RDI;
          end
        end
        S_RDI: state_r <= S_RDJ;
        S_RDJ: state_r <= S_CAP;
        S_CAP: begin
          if (bi_r.color == wanted_r && rd_r.color == wanted_r) state_r <= S_BOX;
          else state_r <= S_NEXT;
        end
        S_BOX: begin
          k_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit_c) begin
            state_r <= S_NEXT;
          end else if (CNT_W'(k_r) == job.count - CNT_W'(1)) begin
            step_r  <= '0;
            state_r <= S_ARITH;
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        S_ARITH: begin
          if (step_r == 4'd12) begin
            if (!qual_c) begin
              state_r <= S_NEXT;
            end else if (!pend_v_r) begin
              pend_v_r     <= 1'b1;
              pend_i_r     <= i_r;
              pend_j_r     <= j_r;
              pend_large_r <= c_gt_r;
              nres_r       <= nres_r + RES_W'(1);
              state_r      <= (nres_r + RES_W'(1) == RES_W'(RESULT_CAP)) ? S_FIN : S_NEXT;
            end else begin
              new_large_r <= c_gt_r;
              state_r     <= S_PUSH;
            end
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_PUSH: begin
          if (can_push) begin
            out_tvalid   <= 1'b1;
            out_tdata    <= {2'b00, 3'(pend_j_r), 3'(pend_i_r)};
            out_tuser    <= {job.ovf, 1'b1, pend_large_r};
            out_tlast    <= 1'b0;
            pend_i_r     <= i_r;
            pend_j_r     <= j_r;
            pend_large_r <= new_large_r;
            nres_r       <= nres_r + RES_W'(1);
            state_r      <= (nres_r + RES_W'(1) == RES_W'(RESULT_CAP)) ? S_FIN : S_NEXT;
          end
        end
        S_NEXT: begin
          if (CNT_W'(j_r) + CNT_W'(1) < job.count) begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= S_RDI;
          end else if (CNT_W'(i_r) + CNT_W'(2) < job.count) begin
            i_r     <= i_r + IDX_W'(1);
            j_r     <= i_r + IDX_W'(2);
            state_r <= S_RDI;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (can_push) begin
            out_tvalid <= 1'b1;
            out_tlast  <= 1'b1;
            if (pend_v_r) begin
              out_tdata <= {2'b00, 3'(pend_j_r), 3'(pend_i_r)};
              out_tuser <= {job.ovf, 1'b1, pend_large_r};
            end else begin
              out_tdata <= '0;
              out_tuser <= {job.ovf, 2'b00};
            end
            pend_v_r <= 1'b0;
            nres_r   <= '0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_pop = (state_r == S_FIN) && can_push;

endmodule

### design/light_bar_pair_matcher_unit.sv
// Top level of the light bar pair matcher.
// Bars are taken one word per cycle while in_tready is high and written to a
// two-bank bar store; the word that carries tlast closes the frame and queues
// it for pair testing, so the next frame can load while the last one is tested
// (up to two frames held, in_tready drops while both banks are busy). Every
// pair i < j is tested in load order by one sequencer: it reads both bars,
// captures them and builds their box, scans the stored bars for containment,
// runs the length ratio, distance windows and angle through the shared
// multiplier and then steps to the next pair. Results leave through an output
// register: found clear means no pair was found, and tlast marks the last
// result of a frame. Config writes belong to idle time.
module light_bar_pair_matcher_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [lbpm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // top_x, top_y, bottom_x, bottom_y, mid_x, mid_y, bar_length, zero fill
  input  logic [111:0]               in_tdata,
  // bar_color
  input  logic                       in_tuser,
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // first_index, second_index, zero fill
  output logic [7:0]                 out_tdata,
  // is_large, found, dropped_bars
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast
);
  import lbpm_pkg::*;

  logic    q_full, q_push, q_valid, q_pop;
  job_t    q_job, q_head;
  bar_wr_t bar_wr;

  lbpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job),
    .bar_wr    (bar_wr)
  );

  lbpm_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  lbpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .bar_wr     (bar_wr),
    .job_valid  (q_valid),
    .job        (q_head),
    .job_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

### design/lbpm_checker.sv
// Port-level checks of the pair matcher and their bind to the top level.
module lbpm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  // a no-pair result closes its frame
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tlast)
    else $error("no-pair result without tlast");

  // a no-pair result carries zero indices and small kind
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == 8'd0 && !out_tuser[0])
    else $error("no-pair result with non-zero fields");

  // a pair's first index lies below its second index
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[2:0] < out_tdata[5:3])
    else $error("pair indices out of order");

endmodule

bind light_bar_pair_matcher_unit lbpm_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### test/light_bar_pair_matcher_unit_tb.sv
// Testbench for the light bar pair matcher: directed frames, back-pressure, random frames, config extremes.
`timescale 1ns / 100ps

module light_bar_pair_matcher_unit_tb;
  import lbpm_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES  = 1500;

  // one bar as sent
  typedef struct {
    logic [14:0] tx, ty, bx, by, cx, cy, len;
    logic        color;
    logic        last;
  } bar_word_t;

  // one pair result
  typedef struct {
    logic [2:0] first_idx, second_idx;
    logic       is_large, found, dropped, last;
  } pair_word_t;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid, in_tready, in_tuser, in_tlast;
  logic [111:0] in_tdata;
  logic        out_tvalid, out_tready, out_tlast;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;

  // predictor state
  logic [15:0] cfg_regs [7];
  bar_word_t   frame_bars [MAX_BARS];
  int          frame_count;
  logic        frame_ovf;
  pair_word_t  pending_pairs [$];
  int          errors;
  int          idle_cycles;
  bit          hold_off;
  bit          watchdog_hit;

  light_bar_pair_matcher_unit dut (.*);

  // clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  function automatic bit point_in_box(int x, int y, int xl, int xh, int yl, int yh);
    return xl <= x && x < xh && yl <= y && y < yh;
  endfunction

  function automatic bit box_blocked(int i, int j);
    int xl, xh, yl, yh;
    int xs [4];
    int ys [4];
    bar_word_t a, b, k;
    a = frame_bars[i]; b = frame_bars[j];
    xs = '{int'(a.tx), int'(a.bx), int'(b.tx), int'(b.bx)};
    ys = '{int'(a.ty), int'(a.by), int'(b.ty), int'(b.by)};
    xl = xs[0]; xh = xs[0]; yl = ys[0]; yh = ys[0];
    for (int n = 1; n < 4; n++) begin
      if (xs[n] < xl) xl = xs[n];
      if (xs[n] > xh) xh = xs[n];
      if (ys[n] < yl) yl = ys[n];
      if (ys[n] > yh) yh = ys[n];
    end
    xl = xl & ~15; xh = (xh & ~15) + 16;
    yl = yl & ~15; yh = (yh & ~15) + 16;
    for (int n = 0; n < frame_count; n++) begin
      k = frame_bars[n];
      if ({k.cy, k.cx} == {a.cy, a.cx} || {k.cy, k.cx} == {b.cy, b.cx}) continue;
      if (point_in_box(int'(k.tx), int'(k.ty), xl, xh, yl, yh) ||
          point_in_box(int'(k.bx), int'(k.by), xl, xh, yl, yh) ||
          point_in_box(int'(k.cx), int'(k.cy), xl, xh, yl, yh))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  // 0 no armour, 1 small, 2 large
  function automatic int armour_kind(int i, int j);
    longint unsigned l1, l2, sh, lo, s, dx, dy, d2, a, b, c, e;
    longint unsigned xi, xj, yi, yj;
    bit small_ok, large_ok;
    l1 = 64'(frame_bars[i].len); l2 = 64'(frame_bars[j].len);
    xi = 64'(frame_bars[i].cx); xj = 64'(frame_bars[j].cx);
    yi = 64'(frame_bars[i].cy); yj = 64'(frame_bars[j].cy);
    sh = l1 < l2 ? l1 : l2; lo = l1 < l2 ? l2 : l1;
    s = l1 + l2;
    dx = xi > xj ? xi - xj : xj - xi;
    dy = yi > yj ? yi - yj : yj - yi;
    d2 = (dx * dx + dy * dy) * 64'd262144;
    if (!(sh * 64'd256 > 64'(cfg_regs[CFG_MIN_RATIO]) * lo)) return 0;
    a = 64'(cfg_regs[CFG_MIN_SMALL]) * s; a = a * a;
    b = 64'(cfg_regs[CFG_MAX_SMALL]) * s; b = b * b;
    c = 64'(cfg_regs[CFG_MIN_LARGE]) * s; c = c * c;
    e = 64'(cfg_regs[CFG_MAX_LARGE]) * s; e = e * e;
    small_ok = a <= d2 && d2 < b;
    large_ok = c <= d2 && d2 < e;
    if (!(small_ok || large_ok)) return 0;
    if (!(dy * 64'd256 < 64'(cfg_regs[CFG_MAX_TANGENT]) * dx)) return 0;
    return d2 > c ? 2 : 1;
  endfunction

  // store a bar and, on the closing bar, queue the frame's pairs
  task automatic predict_bar(bar_word_t w);
    pair_word_t r;
    int n, kind;
    n = 0;
    if (frame_count < MAX_BARS) begin
      frame_bars[frame_count] = w;
      frame_count++;
    end else begin
      frame_ovf = 1'b1;
    end
    if (!w.last) return;
    for (int i = 0; i < frame_count; i++)
      for (int j = i + 1; j < frame_count; j++) begin
        if (n >= RESULT_CAP) break;
        if (frame_bars[i].color != cfg_regs[CFG_WANTED_COLOR][0] ||
            frame_bars[j].color != cfg_regs[CFG_WANTED_COLOR][0]) continue;
        if (box_blocked(i, j)) continue;
        kind = armour_kind(i, j);
        if (kind != 0) begin
          r = '{i[2:0], j[2:0], kind == 2, 1'b1, frame_ovf, 1'b0};
          pending_pairs.push_back(r);
          n++;
        end
      end
    if (n == 0) begin
      r = '{3'd0, 3'd0, 1'b0, 1'b0, frame_ovf, 1'b0};
      pending_pairs.push_back(r);
    end
    pending_pairs[$].last = 1'b1;
    frame_count = 0;
    frame_ovf = 1'b0;
  endtask

  // send one bar word after a random gap; returns at the accepting edge
  task automatic send_bar(bar_word_t w);
    int gap;
    gap = $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {7'd0, w.len, w.cy, w.cx, w.by, w.bx, w.ty, w.tx};
    in_tuser  <= w.color;
    in_tlast  <= w.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_bar(w);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= value;
    case (idx)
      CFG_WANTED_COLOR:             cfg_regs[idx] = value & 16'h1;
      CFG_MIN_RATIO:                cfg_regs[idx] = value & 16'h1ff;
      CFG_MAX_TANGENT:              cfg_regs[idx] = value;
      default:                      cfg_regs[idx] = value & 16'hfff;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering words and wait until the block has drained
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pairs.size() != 0 && !watchdog_hit) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bar_word_t random_bar(bit last);
    bar_word_t w;
    int cx, cy, l;
    cx = $urandom_range(0, 32767); cy = $urandom_range(0, 32767);
    l = $urandom_range(1, 32767);
    w.tx = 15'(cx); w.ty = 15'(cy); w.bx = 15'($urandom); w.by = 15'($urandom);
    w.cx = 15'(cx); w.cy = 15'(cy); w.len = 15'(l);
    w.color = 1'($urandom); w.last = last;
    return w;
  endfunction

  // plausible bar: vertical, length l, centred at (x, y)
  function automatic bar_word_t shaped_bar(int x, int y, int l, bit color, bit last);
    bar_word_t w;
    w.cx = 15'(x); w.cy = 15'(y); w.len = 15'(l);
    w.tx = 15'(x); w.bx = 15'(x); w.ty = 15'(y - l / 2); w.by = 15'(y + l / 2);
    w.color = color; w.last = last;
    return w;
  endfunction

  // a frame of plausible armour pairs with random content and some noise
  task automatic send_shaped_frame(int bars);
    int x, y, l, gap;
    bit col;
    col = ($urandom_range(0, 9) < 8) ? cfg_regs[CFG_WANTED_COLOR][0] : 1'($urandom);
    x = $urandom_range(200, 2000); y = $urandom_range(2000, 30000);
    l = $urandom_range(160, 1600);
    for (int n = 0; n < bars; n++) begin
      gap = $urandom_range(0, 3) == 0 ? l * $urandom_range(30, 45) / 10
                                      : l * $urandom_range(10, 30) / 10;
      if ($urandom_range(0, 7) == 0)
        send_bar(random_bar(n == bars - 1));
      else
        send_bar(shaped_bar(x, y + $urandom_range(0, l / 8),
                            l + $urandom_range(0, l / 5), col, n == bars - 1));
      x = x + gap;
      if (x > 32000) x = $urandom_range(200, 2000);
    end
  endtask

  // directed: extremes of fields, dropped bars, no pair, zero length, vertical, containment
  task automatic test_directed();
    bar_word_t w;
    send_shaped_frame(2);
    send_bar(shaped_bar(1000, 8000, 400, 1'b0, 1'b0));
    send_bar(shaped_bar(1000, 8600, 400, 1'b0, 1'b1));  // vertical centre line
    w = '{15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff, 1'b1, 1'b0};
    send_bar(w);
    w = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd1, 1'b1, 1'b1};
    send_bar(w);
    send_bar(shaped_bar(500, 500, 0, 1'b0, 1'b0));      // zero lengths
    send_bar(shaped_bar(900, 500, 0, 1'b0, 1'b1));
    // containment: middle bar sits in the outer pair's box
    send_bar(shaped_bar(1000, 4000, 400, 1'b0, 1'b0));
    send_bar(shaped_bar(1400, 4000, 400, 1'b0, 1'b0));
    send_bar(shaped_bar(1800, 4000, 400, 1'b0, 1'b1));
    // overflow: ten bars, last dropped bar closes the frame
    send_shaped_frame(10);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    write_reg(CFG_WANTED_COLOR, 16'd1);
    write_reg(CFG_MIN_RATIO, 16'd0);
    write_reg(CFG_MIN_SMALL, 16'd0);
    write_reg(CFG_MAX_SMALL, 16'hfff);
    write_reg(CFG_MIN_LARGE, 16'hfff);
    write_reg(CFG_MAX_LARGE, 16'hfff);
    write_reg(CFG_MAX_TANGENT, 16'hffff);
    for (int f = 0; f < 8; f++) send_shaped_frame($urandom_range(1, 8));
    wait_drained();
    write_reg(CFG_MIN_RATIO, 16'd256);
    write_reg(CFG_MIN_LARGE, 16'd0);
    write_reg(CFG_MAX_TANGENT, 16'd0);
    for (int f = 0; f < 4; f++) send_shaped_frame($urandom_range(1, 6));
  endtask

  // random frames under reset-like and random register values
  task automatic test_random_frames();
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_reg(CFG_WANTED_COLOR, 16'($urandom));
      write_reg(CFG_MIN_RATIO, ph == 0 ? 16'd179 : 16'($urandom_range(0, 256)));
      write_reg(CFG_MIN_SMALL, ph == 0 ? 16'd205 : 16'($urandom_range(0, 400)));
      write_reg(CFG_MAX_SMALL, ph == 0 ? 16'd819 : 16'($urandom_range(600, 1000)));
      write_reg(CFG_MIN_LARGE, ph == 0 ? 16'd819 : 16'($urandom_range(600, 1000)));
      write_reg(CFG_MAX_LARGE, ph == 0 ? 16'd1280 : 16'($urandom_range(1000, 4095)));
      write_reg(CFG_MAX_TANGENT, ph == 0 ? 16'd149 : 16'($urandom_range(0, 2000)));
      for (int f = 0; f < 12; f++) begin
        if ($urandom_range(0, 4) == 0) begin
          int c;
          c = $urandom_range(1, 10);
          for (int n = 0; n < c; n++)
            send_bar(random_bar(n == c - 1));
        end else begin
          send_shaped_frame($urandom_range(2, 9));
        end
      end
    end
  endtask

  // receiver stalls for a long stretch while frames keep coming
  task automatic test_backpressure();
    wait_drained();
    hold_off = 1'b1;
    for (int f = 0; f < 5; f++) send_shaped_frame(3);
    hold_off = 1'b0;
  endtask

  // result sink with random stalls
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (idle_cycles > 0) begin
      idle_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // long hold-off counter for the back-pressure test
  initial begin
    @(posedge hold_off);
    repeat (4000) @(posedge clk);
    hold_off = 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    pair_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      idle_cycles <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (pending_pairs.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        e = pending_pairs.pop_front();
        if (out_tdata[2:0] !== e.first_idx) begin
          $error("first_index exp %0d got %0d", e.first_idx, out_tdata[2:0]); errors++;
        end
        if (out_tdata[5:3] !== e.second_idx) begin
          $error("second_index exp %0d got %0d", e.second_idx, out_tdata[5:3]); errors++;
        end
        if (out_tuser[0] !== e.is_large) begin
          $error("is_large exp %0d got %0d", e.is_large, out_tuser[0]); errors++;
        end
        if (out_tuser[1] !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_tuser[1]); errors++;
        end
        if (out_tuser[2] !== e.dropped) begin
          $error("dropped_bars exp %0d got %0d", e.dropped, out_tuser[2]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_result exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int stall_count;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT && !watchdog_hit) begin
      watchdog_hit = 1'b1;
      $display("light_bar_pair_matcher_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; hold_off = 1'b0; watchdog_hit = 1'b0;
    stall_count = 0;
    frame_count = 0; frame_ovf = 1'b0;
    cfg_regs[CFG_WANTED_COLOR] = 16'd0;  cfg_regs[CFG_MIN_RATIO] = 16'd179;
    cfg_regs[CFG_MIN_SMALL] = 16'd205;   cfg_regs[CFG_MAX_SMALL] = 16'd819;
    cfg_regs[CFG_MIN_LARGE] = 16'd819;   cfg_regs[CFG_MAX_LARGE] = 16'd1280;
    cfg_regs[CFG_MAX_TANGENT] = 16'd149;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_frames();
    test_config_extremes();
    wait_drained();
    if (errors == 0 && pending_pairs.size() == 0)
      $display("light_bar_pair_matcher_unit_tb OK");
    else
      $display("light_bar_pair_matcher_unit_tb NOT OK");
    $finish;
  end

endmodule
